### design/srs_pkg.sv
package srs_pkg;

    // Default data path geometry: signed Q16.16 samples.
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_ERROR_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_A    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_B    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_AR_COEF    = 2'd3;

    // Error model codes.
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_CONST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PROP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_AR1    = 2'd3;

    // Input side-band layout.
    localparam int S_USER_W        = 3;
    localparam int S_USER_OBS_VLD  = 0;
    localparam int S_USER_SIM_VLD  = 1;
    localparam int S_USER_SER_STRT = 2;

endpackage

### design/standardized_residual_stream_core.sv
// Standardized residual core: each input transaction carries one observed and
// one simulated sample (signed fixed point, FRAC_BITS fraction bits) with a
// validity flag for each. When both are valid the core returns one output
// transaction holding (obs - sim) / sd, where sd comes from the error model
// selected by error_mode (constant scale_a, scale_a * sim, or scale_a +
// scale_b * sim); in AR1 mode sd follows the linear model and, once the
// series has a previous eta, the core returns eta - ar_coefficient *
// previous eta. An input with either flag low returns nothing, but its
// series-start flag still clears the AR1 history. Division by zero and any
// clipping to the DATA_WIDTH range set the saturated flag in m_axis_tuser.
// A single multiplier serves both the sd product and the AR1 product, and a
// restoring divider resolves one quotient bit per cycle of a DATA_WIDTH +
// FRAC_BITS + 1 bit quotient (49 bits with Q16.16). The steps are the
// multiply and the sd sum, both skipped in the constant mode, the divider
// set-up, the division and the clipping of eta, which a zero sd replaces by
// a value taken from the sign of the difference, the AR1 multiply and
// subtraction where a correction applies, and the output hand-off. An
// invalid pair leaves the core idle and ready for the next pair. s_axis_tready
// is high only while the core is idle, so no new pair is taken until the last
// result has moved into the output register. A finished result sits in the
// output register and the next pair can be accepted while it waits for
// m_axis_tready; if that register is still full when the next result is
// ready, the core holds it, and the input stalls, until m_axis_tready frees
// the register. Configuration writes must happen only while the core is idle.
module standardized_residual_stream_core #(
    parameter int DATA_WIDTH = srs_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = srs_pkg::FRAC_BITS_DEF,
    localparam int S_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [srs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [DATA_WIDTH-1:0]           cfg_wdata,

    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: obs_value, sim_value, zero padding.
    input  logic [S_TDATA_W-1:0]            s_axis_tdata,
    // Fields from bit 0: obs_valid, sim_valid, series_start.
    input  logic [srs_pkg::S_USER_W-1:0]    s_axis_tuser,

    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: residual, zero padding.
    output logic [M_TDATA_W-1:0]            m_axis_tdata,
    // Fields from bit 0: saturated.
    output logic                            m_axis_tuser
);

    // Internal widths.
    localparam int DW    = DATA_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int DIFFW = DW + 1;          // obs - sim, exact
    localparam int PRODW = 2 * DW;          // full product
    localparam int SHW   = PRODW - FB;      // product after the fraction shift
    localparam int SDW   = SHW + 1;         // sd, exact
    localparam int QW    = DW + FB + 1;     // numerator and quotient magnitude
    localparam int CW    = $clog2(QW);      // iteration counter

    localparam logic [DW-1:0] SCALE_A_RST = DW'(1) << FB;
    localparam logic [DW-1:0] POS_MAX     = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] NEG_MIN     = {1'b1, {(DW-1){1'b0}}};
    localparam logic [CW-1:0] DIV_LAST    = CW'(QW - 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MUL   = 9'b000000010,
        ST_SD    = 9'b000000100,
        ST_PREP  = 9'b000001000,
        ST_DIV   = 9'b000010000,
        ST_ETA   = 9'b000100000,
        ST_ARMUL = 9'b001000000,
        ST_ARSUB = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    // Control state.
    state_t state_reg, state_next;
    logic [srs_pkg::MODE_W-1:0] error_mode_reg, error_mode_next;
    logic [DW-1:0] scale_a_reg, scale_a_next;
    logic [DW-1:0] scale_b_reg, scale_b_next;
    logic [DW-1:0] ar_coef_reg, ar_coef_next;
    logic          have_prev_reg, have_prev_next;
    logic [DW-1:0] last_eta_reg, last_eta_next;
    logic          m_valid_reg, m_valid_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Data path registers.
    logic [DIFFW-1:0] diff_reg, diff_next;
    logic [DW-1:0]    sim_reg, sim_next;
    logic [PRODW-1:0] prod_reg, prod_next;
    logic [SDW-1:0]   sd_reg, sd_next;
    logic [SDW-1:0]   dm_reg, dm_next;
    logic [SDW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic             neg_reg, neg_next;
    logic [DW-1:0]    eta_reg, eta_next;
    logic [DW-1:0]    resid_reg, resid_next;
    logic             flag_reg, flag_next;
    logic [DW-1:0]    m_data_reg, m_data_next;
    logic             m_flag_reg, m_flag_next;

    // Combinational helpers.
    logic             s_fire;
    logic [DW-1:0]    s_obs;
    logic [DW-1:0]    s_sim;
    logic             pair_ok;
    logic [DW-1:0]    mul_a;
    logic [DW-1:0]    mul_b;
    logic [PRODW-1:0] mul_p;
    logic [SHW-1:0]   prod_sh;
    logic [SDW-1:0]   prod_sh_ext;
    logic [SDW-1:0]   scale_a_ext;
    logic [DIFFW-1:0] diff_mag;
    logic [SDW:0]     div_shift;
    logic [SDW+1:0]   div_trial;
    logic [DW-1:0]    q_neg;
    logic [SDW-1:0]   eta_ext;
    logic [SDW-1:0]   ar_wide;
    logic             ar_go;
    logic             out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign s_obs         = s_axis_tdata[DW-1:0];
    assign s_sim         = s_axis_tdata[2*DW-1:DW];
    assign pair_ok       = s_axis_tuser[srs_pkg::S_USER_OBS_VLD]
                        && s_axis_tuser[srs_pkg::S_USER_SIM_VLD];

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(m_data_reg);
    assign m_axis_tuser  = m_flag_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // The shared multiplier: sd product first, AR1 product later.
    always_comb begin
        if (state_reg == ST_ARMUL) begin
            mul_a = ar_coef_reg;
            mul_b = last_eta_reg;
        end else begin
            mul_a = (error_mode_reg == srs_pkg::MODE_PROP) ? scale_a_reg : scale_b_reg;
            mul_b = sim_reg;
        end
    end
    assign mul_p = PRODW'($signed(mul_a) * $signed(mul_b));

    // Arithmetic shift of the product rounds toward minus infinity.
    assign prod_sh     = prod_reg[PRODW-1:FB];
    assign prod_sh_ext = {prod_sh[SHW-1], prod_sh};
    assign scale_a_ext = {{(SDW-DW){scale_a_reg[DW-1]}}, scale_a_reg};

    // Magnitude of the difference; the most negative value maps to 2^DW.
    assign diff_mag = diff_reg[DIFFW-1] ? (~diff_reg + DIFFW'(1)) : diff_reg;

    // One restoring division step.
    assign div_shift = {rem_reg, quo_reg[QW-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, dm_reg};

    assign q_neg = ~quo_reg[DW-1:0] + DW'(1);

    // AR1 correction, exact before saturation.
    assign eta_ext = {{(SDW-DW){eta_reg[DW-1]}}, eta_reg};
    assign ar_wide = eta_ext - prod_sh_ext;

    assign ar_go = (error_mode_reg == srs_pkg::MODE_AR1) && have_prev_reg;

    always_comb begin
        state_next      = state_reg;
        error_mode_next = error_mode_reg;
        scale_a_next    = scale_a_reg;
        scale_b_next    = scale_b_reg;
        ar_coef_next    = ar_coef_reg;
        have_prev_next  = have_prev_reg;
        last_eta_next   = last_eta_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        cnt_next        = cnt_reg;
        diff_next       = diff_reg;
        sim_next        = sim_reg;
        prod_next       = prod_reg;
        sd_next         = sd_reg;
        dm_next         = dm_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        neg_next        = neg_reg;
        eta_next        = eta_reg;
        resid_next      = resid_reg;
        flag_next       = flag_reg;
        m_data_next     = m_data_reg;
        m_flag_next     = m_flag_reg;

        if (cfg_we) begin
            unique case (cfg_addr)
                srs_pkg::REG_ERROR_MODE: error_mode_next = cfg_wdata[srs_pkg::MODE_W-1:0];
                srs_pkg::REG_SCALE_A:    scale_a_next    = cfg_wdata;
                srs_pkg::REG_SCALE_B:    scale_b_next    = cfg_wdata;
                srs_pkg::REG_AR_COEF:    ar_coef_next    = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    // Series start clears the history even for an invalid pair.
                    if (s_axis_tuser[srs_pkg::S_USER_SER_STRT]) begin
                        have_prev_next = 1'b0;
                    end
                    if (pair_ok) begin
                        diff_next = {s_obs[DW-1], s_obs} - {s_sim[DW-1], s_sim};
                        sim_next  = s_sim;
                        flag_next = 1'b0;
                        if (error_mode_reg == srs_pkg::MODE_CONST) begin
                            sd_next    = {{(SDW-DW){scale_a_reg[DW-1]}}, scale_a_reg};
                            state_next = ST_PREP;
                        end else begin
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL: begin
                prod_next  = mul_p;
                state_next = ST_SD;
            end
            ST_SD: begin
                if (error_mode_reg == srs_pkg::MODE_PROP) begin
                    sd_next = prod_sh_ext;
                end else begin
                    sd_next = scale_a_ext + prod_sh_ext;
                end
                state_next = ST_PREP;
            end
            ST_PREP: begin
                if (sd_reg == '0) begin
                    // Division by zero: the sign of the difference picks the bound.
                    flag_next = 1'b1;
                    if (diff_reg == '0) begin
                        eta_next = '0;
                    end else if (diff_reg[DIFFW-1]) begin
                        eta_next = NEG_MIN;
                    end else begin
                        eta_next = POS_MAX;
                    end
                    resid_next = eta_next;
                    state_next = ar_go ? ST_ARMUL : ST_DONE;
                end else begin
                    dm_next    = sd_reg[SDW-1] ? (~sd_reg + SDW'(1)) : sd_reg;
                    neg_next   = diff_reg[DIFFW-1] ^ sd_reg[SDW-1];
                    quo_next   = {diff_mag, {FB{1'b0}}};
                    rem_next   = '0;
                    cnt_next   = DIV_LAST;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!div_trial[SDW+1]) begin
                    rem_next = div_trial[SDW-1:0];
                    quo_next = {quo_reg[QW-2:0], 1'b1};
                end else begin
                    rem_next = div_shift[SDW-1:0];
                    quo_next = {quo_reg[QW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_ETA;
                end
            end
            ST_ETA: begin
                if (neg_reg) begin
                    if (quo_reg > QW'(NEG_MIN)) begin
                        eta_next  = NEG_MIN;
                        flag_next = 1'b1;
                    end else begin
                        eta_next = q_neg;
                    end
                end else begin
                    if (quo_reg > QW'(POS_MAX)) begin
                        eta_next  = POS_MAX;
                        flag_next = 1'b1;
                    end else begin
                        eta_next = quo_reg[DW-1:0];
                    end
                end
                resid_next = eta_next;
                state_next = ar_go ? ST_ARMUL : ST_DONE;
            end
            ST_ARMUL: begin
                prod_next  = mul_p;
                state_next = ST_ARSUB;
            end
            ST_ARSUB: begin
                if ($signed(ar_wide) > $signed({{(SDW-DW){1'b0}}, POS_MAX})) begin
                    resid_next = POS_MAX;
                    flag_next  = 1'b1;
                end else if ($signed(ar_wide) < $signed({{(SDW-DW){1'b1}}, NEG_MIN})) begin
                    resid_next = NEG_MIN;
                    flag_next  = 1'b1;
                end else begin
                    resid_next = ar_wide[DW-1:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = resid_reg;
                    m_flag_next  = flag_reg;
                    if (error_mode_reg == srs_pkg::MODE_AR1) begin
                        last_eta_next  = eta_reg;
                        have_prev_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            error_mode_reg <= srs_pkg::MODE_CONST;
            scale_a_reg    <= SCALE_A_RST;
            scale_b_reg    <= '0;
            ar_coef_reg    <= '0;
            have_prev_reg  <= 1'b0;
            last_eta_reg   <= '0;
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            error_mode_reg <= error_mode_next;
            scale_a_reg    <= scale_a_next;
            scale_b_reg    <= scale_b_next;
            ar_coef_reg    <= ar_coef_next;
            have_prev_reg  <= have_prev_next;
            last_eta_reg   <= last_eta_next;
            m_valid_reg    <= m_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        diff_reg   <= diff_next;
        sim_reg    <= sim_next;
        prod_reg   <= prod_next;
        sd_reg     <= sd_next;
        dm_reg     <= dm_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
        eta_reg    <= eta_next;
        resid_reg  <= resid_next;
        flag_reg   <= flag_next;
        m_data_reg <= m_data_next;
        m_flag_reg <= m_flag_next;
    end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for standardized_residual_stream_core.
// An initial block queues sample pairs and programs the error model between
// phases, only while the core is idle. A clocked driver offers the queued pairs
// on the input stream. At every accepted input transaction it runs the bench's
// own residual predictor, which keeps a private copy of the configuration and
// of the AR1 history. A clocked monitor takes output transactions and compares
// each one, field by field, with the oldest predicted residual.
module tb;

    localparam int     FRAC_BITS    = srs_pkg::FRAC_BITS_DEF;
    localparam longint FRAC_ONE     = 64'sd1 << FRAC_BITS;
    localparam longint WORD_MAX     = 64'sh7FFF_FFFF;
    localparam longint WORD_MIN     = -WORD_MAX - 1;
    localparam int     DRAIN_CYCLES = 80;        // Worst-case busy time of one pair plus margin.
    localparam int     LONG_HOLD    = 400;       // Receiver back-pressure burst, in cycles.
    localparam int     CYCLE_LIMIT  = 1_000_000;

    // One input transaction, split into its fields.
    typedef struct {
        logic signed [31:0] obs;
        logic signed [31:0] sim;
        bit                 obs_ok;
        bit                 sim_ok;
        bit                 first;
    } sample_pair_t;

    // One predicted output transaction.
    typedef struct {
        logic [31:0] residual;
        bit          saturated;
    } residual_t;

    // Clock, reset and all block inputs start at known values.
    logic                           aclk          = 1'b0;
    logic                           aresetn       = 1'b0;
    logic                           cfg_we        = 1'b0;
    logic [srs_pkg::CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [31:0]                    cfg_wdata     = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [63:0]                    s_axis_tdata  = '0;   // obs_value, sim_value
    logic [srs_pkg::S_USER_W-1:0]   s_axis_tuser  = '0;   // obs_valid, sim_valid, series_start
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [31:0]                    m_axis_tdata;         // residual
    logic                           m_axis_tuser;         // saturated

    // Predictor copy of the configuration registers and the AR1 history.
    logic [srs_pkg::MODE_W-1:0] err_mode  = srs_pkg::MODE_CONST;
    longint                     gain_a    = FRAC_ONE;
    longint                     gain_b    = 0;
    longint                     rho       = 0;
    bit                         ar_primed = 1'b0;
    longint                     last_eta  = 0;

    sample_pair_t pair_queue[$];          // Pairs waiting to be offered.
    residual_t    expected_residuals[$];  // Predicted results not yet seen.
    sample_pair_t offered_pair;

    // Idling controls, written by the stimulus at the falling edge only.
    bit src_idle_on   = 1'b1;
    bit sink_idle_on  = 1'b1;
    int hold_requests = 0;

    int send_gap      = 0;
    int stall_left    = 0;
    int hold_left     = 0;
    int holds_served  = 0;
    int mismatch_count = 0;
    int cycle_count   = 0;

    standardized_residual_stream_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 aclk = ~aclk;

    // Clamp a wide value into the signed 32-bit range and flag any clipping.
    function automatic longint clip_to_word(input longint x, inout bit sat);
        if (x > WORD_MAX) begin
            sat = 1'b1;
            return WORD_MAX;
        end
        if (x < WORD_MIN) begin
            sat = 1'b1;
            return WORD_MIN;
        end
        return x;
    endfunction

    // Residual predictor. Runs once per accepted input transaction, in order.
    // The series-start flag clears the AR1 history even when the pair is
    // invalid; an invalid pair predicts nothing.
    function automatic void predict_residual(input sample_pair_t p);
        longint    diff;
        longint    sd;
        longint    eta;
        longint    resid;
        longint    sim_l;
        bit        sat;
        residual_t r;
        sat = 1'b0;
        if (p.first)
            ar_primed = 1'b0;
        if (!(p.obs_ok && p.sim_ok))
            return;
        sim_l = longint'(p.sim);
        diff  = longint'(p.obs) - sim_l;
        // Products are exact; the arithmetic shift rounds toward minus infinity.
        case (err_mode)
            srs_pkg::MODE_CONST: sd = gain_a;
            srs_pkg::MODE_PROP:  sd = (gain_a * sim_l) >>> FRAC_BITS;
            default:             sd = gain_a + ((gain_b * sim_l) >>> FRAC_BITS);
        endcase
        if (sd == 0) begin
            // Division by zero saturates toward the sign of the difference.
            sat = 1'b1;
            eta = (diff > 0) ? WORD_MAX : ((diff < 0) ? WORD_MIN : 0);
        end else begin
            // Signed division truncates toward zero; a negative sd flips the sign.
            eta = clip_to_word((diff * FRAC_ONE) / sd, sat);
        end
        resid = eta;
        if (err_mode == srs_pkg::MODE_AR1) begin
            // The first pair of a series has no history and passes eta as is.
            if (ar_primed)
                resid = clip_to_word(eta - ((rho * last_eta) >>> FRAC_BITS), sat);
            last_eta  = eta;
            ar_primed = 1'b1;
        end
        r.residual  = resid[31:0];
        r.saturated = sat;
        expected_residuals = {expected_residuals, r};
    endfunction

    function automatic void apply_config(input logic [srs_pkg::CFG_ADDR_W-1:0] addr,
                                         input logic [31:0] value);
        case (addr)
            srs_pkg::REG_ERROR_MODE: err_mode = value[srs_pkg::MODE_W-1:0];
            srs_pkg::REG_SCALE_A:    gain_a   = longint'($signed(value));
            srs_pkg::REG_SCALE_B:    gain_b   = longint'($signed(value));
            srs_pkg::REG_AR_COEF:    rho      = longint'($signed(value));
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sample values: extremes, full-range noise, and plausible Q16.16 values.
    function automatic logic [31:0] random_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2:    return $urandom();
            default: return 32'(int'($urandom_range(0, 1048576)) - 524288);
        endcase
    endfunction

    // Error model parameters: extremes, noise, small scales and fractions.
    function automatic logic [31:0] random_param();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 5))
                    0:       return 32'h0000_0000;
                    1:       return 32'h0000_0001;
                    2:       return 32'h7FFF_FFFF;
                    3:       return 32'h8000_0000;
                    4:       return 32'h0001_0000;
                    default: return 32'hFFFF_0000;
                endcase
            end
            1:       return $urandom();
            2, 3:    return 32'(int'($urandom_range(0, 131072)) - 65536);
            default: return 32'(int'($urandom_range(0, 524288)) - 262144);
        endcase
    endfunction

    function automatic logic [srs_pkg::MODE_W-1:0] mode_for_phase(input int ph);
        case (ph % 4)
            0:       return srs_pkg::MODE_CONST;
            1:       return srs_pkg::MODE_PROP;
            2:       return srs_pkg::MODE_LINEAR;
            default: return srs_pkg::MODE_AR1;
        endcase
    endfunction

    // Mostly valid pairs; the rest mark one or both samples as non-finite.
    function automatic sample_pair_t random_pair(input bit first);
        sample_pair_t p;
        p.sim = random_sample();
        if ($urandom_range(0, 3) == 0)
            p.obs = p.sim + 32'(int'($urandom_range(0, 131072)) - 65536);
        else
            p.obs = random_sample();
        case ($urandom_range(0, 15))
            0:       begin p.obs_ok = 1'b0; p.sim_ok = 1'b1; end
            1:       begin p.obs_ok = 1'b1; p.sim_ok = 1'b0; end
            2:       begin p.obs_ok = 1'b0; p.sim_ok = 1'b0; end
            default: begin p.obs_ok = 1'b1; p.sim_ok = 1'b1; end
        endcase
        p.first = first || ($urandom_range(0, 24) == 0);
        return p;
    endfunction

    function automatic void queue_pair(input logic [31:0] obs, input logic [31:0] sim,
                                       input bit obs_ok, input bit sim_ok, input bit first);
        sample_pair_t p;
        p.obs    = obs;
        p.sim    = sim;
        p.obs_ok = obs_ok;
        p.sim_ok = sim_ok;
        p.first  = first;
        pair_queue = {pair_queue, p};
    endfunction

    // One register write; the predictor copy follows at once since the core
    // is idle whenever this runs.
    task automatic write_reg(input logic [srs_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [31:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        apply_config(addr, value);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_model(input logic [31:0] mode_word, input logic [31:0] a,
                             input logic [31:0] b, input logic [31:0] r);
        write_reg(srs_pkg::REG_ERROR_MODE, mode_word);
        write_reg(srs_pkg::REG_SCALE_A, a);
        write_reg(srs_pkg::REG_SCALE_B, b);
        write_reg(srs_pkg::REG_AR_COEF, r);
    endtask

    // Wait until every queued pair has been accepted and every predicted
    // residual has arrived, then let the core settle before touching it.
    task automatic wait_quiet();
        while (pair_queue.size() != 0 || s_axis_tvalid || expected_residuals.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Input driver. The prediction is made at the edge that completes the
    // transaction, so it always sees the configuration the core used.
    always @(posedge aclk) begin : sender
        logic                         busy;
        logic [srs_pkg::S_USER_W-1:0] user;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_residual(offered_pair);
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pair_queue.size() != 0) begin
                    offered_pair = pair_queue.pop_front();
                    user = '0;
                    user[srs_pkg::S_USER_OBS_VLD]  = offered_pair.obs_ok;
                    user[srs_pkg::S_USER_SIM_VLD]  = offered_pair.sim_ok;
                    user[srs_pkg::S_USER_SER_STRT] = offered_pair.first;
                    s_axis_tdata <= {offered_pair.sim, offered_pair.obs};
                    s_axis_tuser <= user;
                    busy = 1'b1;
                    send_gap = src_idle_on ? idle_length() : 0;
                end
            end
            s_axis_tvalid <= busy;
        end
    end

    // Output monitor and receiver back-pressure. A long hold, counted here,
    // starts whenever the stimulus raises hold_requests.
    always @(posedge aclk) begin : receiver
        residual_t want;
        logic      ready;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_residuals.size() == 0) begin
                    report_mismatch($sformatf("result %h/%0b with nothing expected",
                                              m_axis_tdata, m_axis_tuser));
                end else begin
                    want = expected_residuals.pop_front();
                    if (m_axis_tdata !== want.residual)
                        report_mismatch($sformatf("residual %h, expected %h",
                                                  m_axis_tdata, want.residual));
                    if (m_axis_tuser !== want.saturated)
                        report_mismatch($sformatf("saturated %b, expected %b",
                                                  m_axis_tuser, want.saturated));
                end
            end
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready = 1'b0;
            end else begin
                ready = 1'b1;
                if (sink_idle_on && $urandom_range(0, 3) == 0)
                    stall_left = idle_length();
            end
            m_axis_tready <= ready;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0] mode_word;
        int          n_valid;
        sample_pair_t p;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset configuration: constant sd of 1.0. A plain pair, the widest
        // positive and negative differences (both clip), a zero pair that
        // also starts a series, and each kind of invalid pair.
        queue_pair(32'h0001_8000, 32'h0000_4000, 1'b1, 1'b1, 1'b0);
        queue_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
        queue_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0);
        queue_pair(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b1);
        queue_pair(32'h0001_8000, 32'h0000_0000, 1'b0, 1'b1, 1'b0);
        queue_pair(32'h0001_8000, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
        queue_pair(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
        wait_quiet();

        // Zero constant sd with positive, negative and zero differences.
        set_model(32'(srs_pkg::MODE_CONST), 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_pair(32'h0002_0000, 32'h0000_8000, 1'b1, 1'b1, 1'b0);
        queue_pair(32'h0000_8000, 32'h0002_0000, 1'b1, 1'b1, 1'b0);
        queue_pair(32'h0000_4000, 32'h0000_4000, 1'b1, 1'b1, 1'b0);
        wait_quiet();

        // Proportional sd of 0.5 * sim: zero sim gives a zero sd, a negative
        // sim gives a negative sd.
        set_model(32'(srs_pkg::MODE_PROP), 32'h0000_8000, 32'h0000_0000, 32'h0000_0000);
        queue_pair(32'h0001_8000, 32'h0000_0000, 1'b1, 1'b1, 1'b0);
        queue_pair(32'h0001_8000, 32'hFFFD_0000, 1'b1, 1'b1, 1'b0);
        queue_pair(32'h0000_4000, 32'h0002_0000, 1'b1, 1'b1, 1'b0);
        wait_quiet();

        // Linear sd of -2.0 + 1.0 * sim: zero at sim = 2.0, negative below.
        set_model(32'(srs_pkg::MODE_LINEAR), 32'hFFFE_0000, 32'h0001_0000, 32'h0000_0000);
        queue_pair(32'h0001_8000, 32'h0002_0000, 1'b1, 1'b1, 1'b0);
        queue_pair(32'h0001_8000, 32'hFFFD_0000, 1'b1, 1'b1, 1'b0);
        wait_quiet();

        // AR1 with rho = 0.5: first pair of a series, a follower, an invalid
        // pair that restarts the series, and a pair with no history again.
        set_model(32'(srs_pkg::MODE_AR1), 32'h0001_0000, 32'h0000_0000, 32'h0000_8000);
        queue_pair(32'h0001_8000, 32'h0000_0000, 1'b1, 1'b1, 1'b1);
        queue_pair(32'h0002_0000, 32'h0000_8000, 1'b1, 1'b1, 1'b0);
        queue_pair(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
        queue_pair(32'h0000_8000, 32'h0000_4000, 1'b1, 1'b1, 1'b0);
        queue_pair(32'hFFFD_0000, 32'h0002_0000, 1'b1, 1'b1, 1'b0);
        wait_quiet();

        // Tiny sd and the largest rho: eta clips, and the AR1 term clips too.
        set_model(32'(srs_pkg::MODE_AR1), 32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF);
        queue_pair(32'h0002_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b1);
        queue_pair(32'h0000_8000, 32'h0000_0000, 1'b1, 1'b1, 1'b0);
        queue_pair(32'h0000_4000, 32'h0000_8000, 1'b1, 1'b1, 1'b0);
        wait_quiet();

        // Random phases: each one programs a fresh error model (extremes in
        // the first two, stray upper bits in the mode word) and then streams
        // series of random pairs.
        for (int ph = 0; ph < 14; ph++) begin
            mode_word = $urandom();
            mode_word[srs_pkg::MODE_W-1:0] = mode_for_phase(ph);
            if (ph == 0)
                set_model(mode_word, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
            else if (ph == 1)
                set_model(mode_word, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            else
                set_model(mode_word, random_param(), random_param(), random_param());

            src_idle_on  = (ph % 3 != 2);
            sink_idle_on = (ph % 4 != 3);
            if (ph == 5) begin
                // Stall the receiver for a long stretch while the sender
                // streams without gaps, so the core backs up its input.
                src_idle_on = 1'b0;
                hold_requests++;
            end

            n_valid = 0;
            while (n_valid < 58) begin
                p = random_pair(n_valid == 0);
                pair_queue = {pair_queue, p};
                if (p.obs_ok && p.sim_ok)
                    n_valid++;
                // Mid-phase pause: the sender stops until the core drains.
                if (ph == 7 && n_valid == 29 && p.obs_ok && p.sim_ok)
                    wait_quiet();
            end
            wait_quiet();
        end

        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

### sim.f
design/srs_pkg.sv
design/standardized_residual_stream_core.sv
test/tb.sv
